/* hw/rtl/sma_pkg.sv */
// Shared types, codes and helpers for the small matrix arithmetic engine.
// No dependencies.
package sma_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 3;                 // row/column index width
  localparam int ADDR_W    = 2 * IDX_W;         // element address {row, col}
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int DIM_W     = 4;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 52;                // 8 shifted Q16.16 products never overflow

  // Input actions
  localparam logic [1:0] ACT_WR_A = 2'd0;
  localparam logic [1:0] ACT_WR_B = 2'd1;
  localparam logic [1:0] ACT_CMP  = 2'd2;

  // Operation modes
  localparam logic [2:0] MODE_MUL  = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_SCL  = 3'd3;
  localparam logic [2:0] MODE_ADDK = 3'd4;
  localparam logic [2:0] MODE_TRN  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_A_ROWS = 3'd0;
  localparam logic [2:0] REG_A_COLS = 3'd1;
  localparam logic [2:0] REG_B_COLS = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_K      = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              acc_clr;
    logic              emit;
    logic [IDX_W-1:0]  emit_row;
    logic [IDX_W-1:0]  emit_col;
    logic              emit_last;
  } sma_cmd_t;

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

endpackage

/* hw/rtl/sma_datapath.sv */
// Datapath: A/B element memories, multiply/add pipeline, accumulator, result register.
// Depends on sma_pkg.
module sma_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sma_pkg::sma_cmd_t             cmd,
  input  logic [sma_pkg::DATA_W-1:0]    wr_data,
  input  logic [2:0]                    mode,
  input  logic signed [sma_pkg::DATA_W-1:0] scalar_k,
  output logic                          out_valid,
  output logic [2:0]                    out_row,
  output logic [2:0]                    out_col,
  output logic signed [31:0]            out_value,
  output logic                          out_last
);
  import sma_pkg::*;

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];
  logic [DEPTH-1:0]  a_vld_r, b_vld_r;

  logic signed [DATA_W-1:0]   a_q_r, b_q_r;
  logic                       s1_vld_r, s2_vld_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [DATA_W:0]     sum_r;
  logic signed [DATA_W:0]     sum_nxt;
  logic signed [DATA_W-1:0]   mul_b;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [DATA_W-1:0]   sat_val;

  logic                       out_valid_r, out_last_r;
  logic [IDX_W-1:0]           out_row_r, out_col_r;
  logic signed [DATA_W-1:0]   out_value_r;

  // Element stores; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (cmd.wr_a) a_mem[cmd.wr_addr] <= wr_data;
    if (cmd.wr_b) b_mem[cmd.wr_addr] <= wr_data;
    a_q_r <= a_vld_r[cmd.rd_addr_a] ? a_mem[cmd.rd_addr_a] : '0;
    b_q_r <= b_vld_r[cmd.rd_addr_b] ? b_mem[cmd.rd_addr_b] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= '0;
    end else begin
      if (cmd.wr_a) a_vld_r[cmd.wr_addr] <= 1'b1;
      if (cmd.wr_b) b_vld_r[cmd.wr_addr] <= 1'b1;
    end
  end

  // Stage 2 operands: product and plain sum
  assign mul_b = (mode == MODE_SCL) ? scalar_k : b_q_r;

  always_comb begin
    case (mode)
      MODE_ADD:  sum_nxt = {a_q_r[DATA_W-1], a_q_r} + {b_q_r[DATA_W-1], b_q_r};
      MODE_SUB:  sum_nxt = {a_q_r[DATA_W-1], a_q_r} - {b_q_r[DATA_W-1], b_q_r};
      MODE_ADDK: sum_nxt = {a_q_r[DATA_W-1], a_q_r} + {scalar_k[DATA_W-1], scalar_k};
      default:   sum_nxt = {a_q_r[DATA_W-1], a_q_r};
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= a_q_r * mul_b;
    sum_r  <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.rd;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Stage 3: floor shift of product, accumulate
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign term = (mode == MODE_MUL || mode == MODE_SCL) ? prod_sh[ACC_W-1:0]
                                                       : ACC_W'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + term;
    end
  end

  // Saturate to 32 bits
  always_comb begin
    if (acc_r > ACC_W'(signed'(32'sh7fffffff)))
      sat_val = 32'sh7fffffff;
    else if (acc_r < ACC_W'(signed'(32'sh80000000)))
      sat_val = 32'sh80000000;
    else
      sat_val = acc_r[DATA_W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cmd.emit_row;
      out_col_r   <= cmd.emit_col;
      out_value_r <= sat_val;
      out_last_r  <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

/* hw/rtl/sma_ctrl.sv */
// Controller: walks result elements and dot-product terms, issues datapath commands.
// Depends on sma_pkg.
module sma_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0]                  action,
  input  logic [2:0]                  row,
  input  logic [2:0]                  col,
  input  logic [sma_pkg::DIM_W-1:0]   a_rows,
  input  logic [sma_pkg::DIM_W-1:0]   a_cols,
  input  logic [sma_pkg::DIM_W-1:0]   b_cols,
  input  logic [2:0]                  mode,
  output logic                        busy,
  output sma_pkg::sma_cmd_t           cmd
);
  import sma_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt, c_r, c_nxt, t_r, t_nxt;
  logic             w_r, w_nxt;
  logic [DIM_W-1:0] ar, ac, bc, nr, nc, nt;
  logic             row_end, col_end, term_end, go;

  // Result shape from the configured mode
  always_comb begin
    ar = dim_clamp(a_rows);
    ac = dim_clamp(a_cols);
    bc = dim_clamp(b_cols);
    nr = (mode == MODE_TRN) ? ac : ar;
    nc = (mode == MODE_TRN) ? ar : ((mode == MODE_MUL) ? bc : ac);
    nt = (mode == MODE_MUL) ? ac : DIM_W'(1);
  end

  assign row_end  = ({1'b0, r_r} == nr - DIM_W'(1));
  assign col_end  = ({1'b0, c_r} == nc - DIM_W'(1));
  assign term_end = ({1'b0, t_r} == nt - DIM_W'(1));
  assign go       = start && (state_r == S_IDLE) && (action == ACT_CMP) && (mode <= MODE_TRN);
  assign busy     = (state_r != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r;
    c_nxt = c_r;
    t_nxt = t_r;
    w_nxt = w_r;
    cmd = '0;
    cmd.wr_addr   = {row, col};
    cmd.emit_row  = r_r;
    cmd.emit_col  = c_r;
    cmd.emit_last = row_end && col_end;
    if (mode == MODE_MUL) begin
      cmd.rd_addr_a = {r_r, t_r};
      cmd.rd_addr_b = {t_r, c_r};
    end else if (mode == MODE_TRN) begin
      cmd.rd_addr_a = {c_r, r_r};
      cmd.rd_addr_b = {c_r, r_r};
    end else begin
      cmd.rd_addr_a = {r_r, c_r};
      cmd.rd_addr_b = {r_r, c_r};
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.wr_a = (action == ACT_WR_A);
          cmd.wr_b = (action == ACT_WR_B);
        end
        if (go) begin
          cmd.acc_clr = 1'b1;
          r_nxt = '0;
          c_nxt = '0;
          t_nxt = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.rd = 1'b1;
        t_nxt = t_r + IDX_W'(1);
        if (term_end) begin
          t_nxt = '0;
          w_nxt = 1'b0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        w_nxt = 1'b1;
        if (w_r) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        cmd.acc_clr = 1'b1;
        if (col_end) begin
          c_nxt = '0;
          r_nxt = r_r + IDX_W'(1);
        end else begin
          c_nxt = c_r + IDX_W'(1);
        end
        state_nxt = (row_end && col_end) ? S_IDLE : S_ISSUE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r <= '0;
      c_r <= '0;
      t_r <= '0;
      w_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      r_r <= r_nxt;
      c_r <= c_nxt;
      t_r <= t_nxt;
      w_r <= w_nxt;
    end
  end

  // Checks
  a_go: assert property (@(posedge clk) disable iff (!rst_n) go |=> state_r == S_ISSUE)
    else $error("compute request did not start");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && row_end && col_end) |=> state_r == S_IDLE)
    else $error("last element did not end the run");
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> $past(state_r) == S_WAIT)
    else $error("emit without pipeline drain");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ({1'b0, r_r} < nr && {1'b0, c_r} < nc))
    else $error("element counter out of range");

endmodule

/* hw/rtl/small_matrix_arithmetic_engine.sv */
// Small matrix arithmetic engine, top level: configuration registers and wiring.
// Depends on sma_pkg, sma_ctrl, sma_datapath.
//
// Write requests (A or B element) leave busy low. A compute request raises busy
// and emits the result matrix row-major, one element per out_valid pulse,
// out_last on the final one; the receiver cannot stall, so each element must be
// taken in the cycle it is shown. Each element sums n terms, where n is the
// number of columns of A in multiply mode and 1 in the other modes: one shared
// multiplier with a two-stage read/multiply pipeline feeds an accumulator,
// drained before each element. Invalid modes and action 3 produce nothing.
// Stored elements read as zero after reset.
module small_matrix_arithmetic_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_action,
  input  logic [2:0]             in_row,
  input  logic [2:0]             in_col,
  input  logic signed [31:0]     in_value,
  output logic                   out_valid,
  output logic [2:0]             out_row,
  output logic [2:0]             out_col,
  output logic signed [31:0]     out_value,
  output logic                   out_last,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_idx,
  input  logic [31:0]            cfg_wdata
);
  import sma_pkg::*;

  logic [DIM_W-1:0]         a_rows_r, a_cols_r, b_cols_r;
  logic [2:0]               mode_r;
  logic signed [DATA_W-1:0] k_r;
  sma_cmd_t                 cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(1);
      a_cols_r <= DIM_W'(1);
      b_cols_r <= DIM_W'(1);
      mode_r   <= MODE_MUL;
      k_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_A_ROWS: a_rows_r <= cfg_wdata[DIM_W-1:0];
        REG_A_COLS: a_cols_r <= cfg_wdata[DIM_W-1:0];
        REG_B_COLS: b_cols_r <= cfg_wdata[DIM_W-1:0];
        REG_MODE:   mode_r   <= cfg_wdata[2:0];
        REG_K:      k_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sma_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .row    (in_row),
    .col    (in_col),
    .a_rows (a_rows_r),
    .a_cols (a_cols_r),
    .b_cols (b_cols_r),
    .mode   (mode_r),
    .busy   (busy),
    .cmd    (cmd)
  );

  sma_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_data   (in_value),
    .mode      (mode_r),
    .scalar_k  (k_r),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

/* tb/sma_checker.sv */
// Result checker for the small matrix arithmetic engine: mirrors A, B and the
// registers, predicts each result element and compares. Depends on sma_pkg.
module sma_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_row,
  input  logic [2:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic [2:0]         out_row,
  input  logic [2:0]         out_col,
  input  logic signed [31:0] out_value,
  input  logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  output int                 pending,
  output int                 errors,
  output int                 elems_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sma_pkg::*;

  typedef struct packed {
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] v;
    logic        lst;
  } elem_t;

  logic [31:0] mat_a [DEPTH];
  logic [31:0] mat_b [DEPTH];
  logic [3:0]  rows_q, cols_q, bcols_q;
  logic [2:0]  mode_q;
  logic [31:0] k_q;
  elem_t       elem_fifo[$];

  assign pending = elem_fifo.size();

  function automatic int clampdim(logic [3:0] d);
    if (d == 4'd0) return 1;
    if (d > 4'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic logic [31:0] sat(logic signed [127:0] v);
    if (v > 128'sh7fffffff) return 32'h7fffffff;
    if (v < -128'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] aval(int r, int c);
    return 128'(signed'(mat_a[r*MAX_DIM+c]));
  endfunction

  function automatic logic signed [127:0] bval(int r, int c);
    return 128'(signed'(mat_b[r*MAX_DIM+c]));
  endfunction

  // Expand one compute request into its row-major result elements
  task automatic predict_matrix();
    int nr, nc, ar, ac, bc;
    logic signed [127:0] acc, kk;
    elem_t e;
    ar = clampdim(rows_q); ac = clampdim(cols_q); bc = clampdim(bcols_q);
    kk = 128'(signed'(k_q));
    if (mode_q > MODE_TRN) return;
    nr = ar; nc = ac;
    if (mode_q == MODE_MUL) nc = bc;
    if (mode_q == MODE_TRN) begin
      nr = ac; nc = ar;
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) begin
        case (mode_q)
          MODE_MUL: begin
            acc = 0;
            for (int t = 0; t < ac; t++) acc += (aval(r, t) * bval(t, c)) >>> FRAC_BITS;
            e.v = sat(acc);
          end
          MODE_ADD:  e.v = sat(aval(r, c) + bval(r, c));
          MODE_SUB:  e.v = sat(aval(r, c) - bval(r, c));
          MODE_SCL:  e.v = sat((aval(r, c) * kk) >>> FRAC_BITS);
          MODE_ADDK: e.v = sat(aval(r, c) + kk);
          default:   e.v = mat_a[c*MAX_DIM+r];
        endcase
        e.r = 3'(r); e.c = 3'(c); e.lst = (r == nr-1) && (c == nc-1);
        elem_fifo.push_back(e);
      end
  endtask

  always @(posedge clk) begin
    elem_t x;
    if (!rst_n) begin
      foreach (mat_a[i]) begin
        mat_a[i] = '0; mat_b[i] = '0;
      end
      rows_q = 4'd1; cols_q = 4'd1; bcols_q = 4'd1; mode_q = MODE_MUL; k_q = '0;
      elem_fifo.delete();
      errors = 0;
      elems_seen = 0;
    end else begin
      // check an emitted element
      if (out_valid) begin
        elems_seen++;
        if (elem_fifo.size() == 0) begin
          $error("unexpected result element row %0d col %0d", out_row, out_col);
          errors++;
        end else begin
          x = elem_fifo.pop_front();
          if (out_row !== x.r) begin
            $error("out_row exp %0d got %0d", x.r, out_row); errors++;
          end
          if (out_col !== x.c) begin
            $error("out_col exp %0d got %0d", x.c, out_col); errors++;
          end
          if (out_value !== x.v) begin
            $error("out_value exp %h got %h", x.v, out_value); errors++;
          end
          if (out_last !== x.lst) begin
            $error("out_last exp %0d got %0d", x.lst, out_last); errors++;
          end
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_A_ROWS: rows_q  = cfg_wdata[3:0];
          REG_A_COLS: cols_q  = cfg_wdata[3:0];
          REG_B_COLS: bcols_q = cfg_wdata[3:0];
          REG_MODE:   mode_q  = cfg_wdata[2:0];
          REG_K:      k_q     = cfg_wdata;
          default: ;
        endcase
      end
      // accepted request
      if (start && !busy) begin
        case (in_action)
          ACT_WR_A: mat_a[{in_row, in_col}] = in_value;
          ACT_WR_B: mat_b[{in_row, in_col}] = in_value;
          ACT_CMP:  predict_matrix();
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/testbench.sv */
// Top of the testbench for the small matrix arithmetic engine: clock, reset,
// register phases and request stimulus. Depends on sma_pkg and sma_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sma_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [1:0]         in_action = 0;
  logic [2:0]         in_row = 0;
  logic [2:0]         in_col = 0;
  logic signed [31:0] in_value = 0;
  logic               out_valid;
  logic [2:0]         out_row, out_col;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               cfg_we = 0;
  logic [2:0]         cfg_idx = 0;
  logic [31:0]        cfg_wdata = 0;
  logic               req_taken = 0;
  int                 pending, errors, elems_seen;
  int                 cycles = 0;
  int                 requests = 0;
  int                 burst_left = 0;

  localparam int CYCLE_LIMIT = 600000;

  always #4 clk = ~clk;

  small_matrix_arithmetic_engine dut (.*);
  sma_checker chk (.*);

  // Run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Request handshake as seen at the rising edge
  always @(posedge clk) req_taken <= start && !busy;

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_idx = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Drive one request; bursts with random gaps in between
  task automatic send(logic [1:0] act, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    if (burst_left == 0) begin
      start = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start = 1; in_action = act; in_row = r; in_col = c; in_value = v;
    do @(negedge clk); while (!req_taken);
    requests++;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 8)) - 4) << 16;
      3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // Wait for the matrix to drain before touching registers
  task automatic settle();
    start = 0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic fill(int n);
    repeat (n) send(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), rand_val());
  endtask

  task automatic compute();
    send(ACT_CMP, 3'($urandom), 3'($urandom), $urandom);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1;

    // Directed: extreme values, each mode at full size, clamped dimensions
    set_reg(REG_A_ROWS, 8); set_reg(REG_A_COLS, 8); set_reg(REG_B_COLS, 8);
    set_reg(REG_K, 32'h80000000);
    send(ACT_WR_A, 3'd7, 3'd7, 32'h7fffffff);
    send(ACT_WR_A, 3'd0, 3'd0, 32'h80000000);
    send(ACT_WR_A, 3'd0, 3'd7, 32'h80000000);
    send(ACT_WR_B, 3'd7, 3'd0, 32'h80000000);
    send(ACT_WR_B, 3'd0, 3'd0, 32'h80000000);
    send(ACT_WR_B, 3'd7, 3'd7, 32'h7fffffff);
    send(ACT_UNUSED, 3'd5, 3'd2, 32'h12345678);
    for (int m = 0; m < 8; m++) begin
      settle();
      set_reg(REG_MODE, m);
      compute();
    end
    settle();
    set_reg(REG_A_ROWS, 0); set_reg(REG_A_COLS, 15); set_reg(REG_B_COLS, 9);
    set_reg(REG_MODE, MODE_TRN); set_reg(REG_K, 32'h7fffffff);
    compute();
    settle();
    set_reg(REG_MODE, MODE_ADDK);
    compute();

    // Random phases: mostly small sizes, a few drawn from the whole range
    for (int ph = 0; ph < 24; ph++) begin
      settle();
      set_reg(REG_A_ROWS, ph % 6 == 0 ? $urandom_range(0, 15) : $urandom_range(1, 3));
      set_reg(REG_A_COLS, ph % 6 == 0 ? $urandom_range(0, 15) : $urandom_range(1, 3));
      set_reg(REG_B_COLS, ph % 6 == 0 ? $urandom_range(0, 15) : $urandom_range(1, 3));
      set_reg(REG_MODE, ph % 8 == 7 ? $urandom_range(6, 7) : $urandom_range(0, 5));
      set_reg(REG_K, rand_val());
      repeat (2) begin
        fill($urandom_range(3, 6));
        compute();
      end
    end
    settle();
    repeat (40) @(negedge clk);

    $display("covered %0d requests, %0d result elements checked", requests, elems_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
